FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the playout block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// condition that must never be seen on a rising edge
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/arpv_pkg.sv
// ----------------------------------------------------------------------------
// arpv_pkg
// Constants, codes, types and helper functions for the audio playout block
// ----------------------------------------------------------------------------
`default_nettype none

package arpv_pkg;

	// ring buffer and window sizing
	localparam int BUF_DEPTH    = 1024;
	localparam int AW           = $clog2(BUF_DEPTH);
	localparam int LOW_MARK     = 128;
	localparam int WINDOW_TICKS = 1024;
	localparam int PH_W         = $clog2(WINDOW_TICKS);

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int POT_W    = 12;
	localparam int DAC_W    = 10;
	localparam int PCT_W    = 7;
	localparam int VU_W     = 3;
	localparam int GAIN_W   = 24;
	localparam int LEVEL_W  = 26;
	localparam int VOL_W    = 16;
	localparam int POTK_W   = 6;
	localparam int POTV_W   = 9;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_USB_VOLUME = 2'd0,
		REG_MUTE       = 2'd1,
		REG_RUNNING    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	// arithmetic constants
	localparam logic [VOL_W-1:0]    VOL_MIN_CODE = 16'h8000;
	localparam logic [SAMPLE_W-1:0] BIAS         = 16'h8000;
	localparam logic [DAC_W-1:0]    DAC_MID      = DAC_W'(BIAS >> (SAMPLE_W - DAC_W));
	localparam logic [VU_W-1:0]     VU_MAX       = 3'd7;
	localparam int                  VU_SHIFT     = 20;
	localparam int                  PCT_SCALE    = 100;
	localparam int                  POT_FULL     = 1023;

	// ring buffer commands from the front end
	typedef struct packed {
		logic push;
		logic pop;
	} ring_cmd_t;

	// pot reading reduced to a step count: pot value is this times eight
	function automatic logic [POTK_W-1:0] pot_step(input logic [POT_W-1:0] r);
		logic [POTK_W-1:0] k;
		k = POTK_W'(r[11:7]) + POTK_W'(r[6]);
		return k;
	endfunction

	// percentage = (k * 8 * 100) / 1023, split at 1024 with one correction
	function automatic logic [PCT_W-1:0] pct_of(input logic [POTK_W-1:0] k);
		logic [14:0] x;
		logic [4:0]  q0;
		logic [10:0] rem;
		logic [PCT_W-1:0] q;
		x   = 15'(k) * 15'(PCT_SCALE * 8);
		q0  = x[14:10];
		rem = 11'(x[9:0]) + 11'(q0);
		q   = PCT_W'(q0) + PCT_W'(rem >= 11'(POT_FULL));
		return q;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/arpv_ring.sv
// ----------------------------------------------------------------------------
// arpv_ring
// Sample ring buffer: write and read pointers, fill-level read pacing and
// the sample memory with a registered read port
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module arpv_ring (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire arpv_pkg::ring_cmd_t                cmd,
	input  wire logic [arpv_pkg::SAMPLE_W-1:0]      wr_data,
	output logic      [arpv_pkg::SAMPLE_W-1:0]      rd_data
);

	logic [arpv_pkg::SAMPLE_W-1:0] mem [arpv_pkg::BUF_DEPTH];
	logic [arpv_pkg::SAMPLE_W-1:0] rd_q;

	logic [arpv_pkg::AW-1:0] wp_q;
	logic [arpv_pkg::AW-1:0] rp_q;
	logic [arpv_pkg::AW:0]   diff;
	logic [arpv_pkg::AW-1:0] fill;
	logic [1:0]              step;
	logic [arpv_pkg::AW:0]   rp_sum;
	logic [arpv_pkg::AW-1:0] rp_next;
	logic [arpv_pkg::AW:0]   wp_sum;
	logic [arpv_pkg::AW-1:0] wp_next;

	// fill level and read pointer pacing
	always_comb begin
		diff = {1'b0, wp_q} - {1'b0, rp_q};
		if (diff[arpv_pkg::AW]) begin
			fill = arpv_pkg::AW'(diff + (arpv_pkg::AW+1)'(arpv_pkg::BUF_DEPTH));
		end else begin
			fill = diff[arpv_pkg::AW-1:0];
		end
		step = 2'(fill == arpv_pkg::AW'(arpv_pkg::BUF_DEPTH - arpv_pkg::LOW_MARK))
			+ 2'(fill > arpv_pkg::AW'(arpv_pkg::LOW_MARK));
		rp_sum = {1'b0, rp_q} + (arpv_pkg::AW+1)'(step);
		if (rp_sum >= (arpv_pkg::AW+1)'(arpv_pkg::BUF_DEPTH)) begin
			rp_next = arpv_pkg::AW'(rp_sum - (arpv_pkg::AW+1)'(arpv_pkg::BUF_DEPTH));
		end else begin
			rp_next = rp_sum[arpv_pkg::AW-1:0];
		end
		wp_sum = {1'b0, wp_q} + (arpv_pkg::AW+1)'(1);
		if (wp_sum >= (arpv_pkg::AW+1)'(arpv_pkg::BUF_DEPTH)) begin
			wp_next = '0;
		end else begin
			wp_next = wp_sum[arpv_pkg::AW-1:0];
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (cmd.push) begin
				wp_q <= wp_next;
			end
			if (cmd.pop) begin
				rp_q <= rp_next;
			end
		end
	end

	// sample memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wp_q] <= wr_data;
		end
		if (cmd.pop) begin
			rd_q <= mem[rp_q];
		end
	end

	assign rd_data = rd_q;

	`ASSERT_NEVER(a_push_pop_excl, clk, arst_n, cmd.push && cmd.pop,
		"ring push and pop in one cycle")
	`ASSERT_CLK(a_pop_moves, clk, arst_n,
		(cmd.pop && fill > arpv_pkg::AW'(arpv_pkg::LOW_MARK)) |=> (rp_q != $past(rp_q)),
		"read pointer held although fill is above the low mark")
	`ASSERT_CLK(a_rp_holds, clk, arst_n,
		!cmd.pop |=> $stable(rp_q),
		"read pointer moved without a pop")

endmodule

`default_nettype wire

FILE: rtl/audio_ring_playout_volume_unit.sv
// ----------------------------------------------------------------------------
// audio_ring_playout_volume_unit
// Ring buffer audio playout with volume scaling, DAC coding and VU metering
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a beat with kind = push stores sample
// in the ring buffer and gives no result; a beat with kind = tick plays one
// sample if running and gives exactly one result beat on the output channel
// (out_valid / out_stall) with dac_code, vol_pct, vu_level and window_done.
// Every WINDOW_TICKS-th tick (the first after reset included) takes pot_sample
// to refresh the gain, the percentage and the VU level and flags window_done.
// A tick accepted passes stage 1, stage 2 and the output register in turn.
// Throughput: one beat per cycle while in_stall is low, pushes and ticks mixed
// in any order; the single registered read port of the sample memory and the
// three-stage pipeline (read, scale and meter, output) set that figure.
// Registers usb_volume, mute and running are written through the cfg port.
// Reset clears pointers, gain, VU sum, registers and the pipeline; the sample
// memory is not cleared, so entries read before being written are undefined.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised; a free or taken output register lets a new beat in.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module audio_ring_playout_volume_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write port
	input  wire logic                                 cfg_wr_en,
	input  wire logic [arpv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [arpv_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input channel
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 kind,
	input  wire logic signed [arpv_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [arpv_pkg::POT_W-1:0]           pot_sample,
	// output channel
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [arpv_pkg::DAC_W-1:0]                dac_code,
	output logic [arpv_pkg::PCT_W-1:0]                vol_pct,
	output logic [arpv_pkg::VU_W-1:0]                 vu_level,
	output logic                                      window_done
);

	// configuration registers
	logic [arpv_pkg::VOL_W-1:0] usb_volume_q;
	logic                       mute_q;
	logic                       running_q;

	// front end
	logic                       adv;
	logic                       acc;
	logic                       tick;
	arpv_pkg::ring_cmd_t        ring_cmd;
	logic [arpv_pkg::PH_W-1:0]  phase_q;
	logic                       window;
	logic [arpv_pkg::SAMPLE_W-1:0] rd_data;

	// stage 1
	logic                          valid_s1;
	logic                          play_s1;
	logic                          mute_s1;
	logic                          window_s1;
	logic [arpv_pkg::POTK_W-1:0]   k_s1;

	// metering and scaling state
	logic [arpv_pkg::GAIN_W-1:0]  gain_q;
	logic [arpv_pkg::LEVEL_W-1:0] level_q;
	logic [arpv_pkg::PCT_W-1:0]   pct_q;
	logic [arpv_pkg::VU_W-1:0]    vu_q;

	// stage 1 logic
	logic [arpv_pkg::SAMPLE_W-1:0]  mag;
	logic [arpv_pkg::LEVEL_W:0]     sum_wide;
	logic [arpv_pkg::LEVEL_W-1:0]   sum_next;
	logic [arpv_pkg::LEVEL_W-arpv_pkg::VU_SHIFT-1:0] level_hi;
	logic [arpv_pkg::VU_W-1:0]      vu_new;
	logic signed [arpv_pkg::SAMPLE_W+arpv_pkg::GAIN_W:0] prod;
	logic [arpv_pkg::POTV_W-1:0]    pot;
	logic [arpv_pkg::GAIN_W:0]      vol_x_pot;
	logic [arpv_pkg::GAIN_W-1:0]    gain_new;
	logic [arpv_pkg::PCT_W-1:0]     pct_next;
	logic [arpv_pkg::VU_W-1:0]      vu_next;

	// stage 2
	logic                          valid_s2;
	logic                          quiet_s2;
	logic                          window_s2;
	logic [arpv_pkg::SAMPLE_W-1:0] hi_s2;
	logic [arpv_pkg::PCT_W-1:0]    pct_s2;
	logic [arpv_pkg::VU_W-1:0]     vu_s2;
	logic [arpv_pkg::SAMPLE_W-1:0] biased;

	// output register
	logic                       out_valid_q;
	logic [arpv_pkg::DAC_W-1:0] dac_q;
	logic [arpv_pkg::PCT_W-1:0] pct_out_q;
	logic [arpv_pkg::VU_W-1:0]  vu_out_q;
	logic                       done_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usb_volume_q <= '0;
			mute_q       <= 1'b0;
			running_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				arpv_pkg::REG_USB_VOLUME: usb_volume_q <= cfg_data[arpv_pkg::VOL_W-1:0];
				arpv_pkg::REG_MUTE:       mute_q       <= cfg_data[0];
				arpv_pkg::REG_RUNNING:    running_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake: the whole pipeline moves unless a result sits stalled
	assign in_stall = out_valid_q && out_stall;
	assign adv      = !in_stall;
	assign acc      = in_valid && adv;
	assign tick     = acc && (kind == arpv_pkg::KIND_TICK);
	assign window   = (phase_q == '0);

	assign ring_cmd.push = acc && (kind == arpv_pkg::KIND_PUSH);
	assign ring_cmd.pop  = tick && running_q;

	arpv_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ring_cmd),
		.wr_data (sample),
		.rd_data (rd_data)
	);

	// window phase counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (tick) begin
			if (phase_q == arpv_pkg::PH_W'(arpv_pkg::WINDOW_TICKS - 1)) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_q + arpv_pkg::PH_W'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= tick;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			play_s1   <= running_q;
			mute_s1   <= mute_q;
			window_s1 <= window;
			k_s1      <= arpv_pkg::pot_step(pot_sample);
		end
	end

	// magnitude, saturating VU sum, product and new gain
	always_comb begin
		if (rd_data[arpv_pkg::SAMPLE_W-1]) begin
			mag = arpv_pkg::SAMPLE_W'(~rd_data + arpv_pkg::SAMPLE_W'(1));
		end else begin
			mag = rd_data;
		end
		sum_wide = {1'b0, level_q} + (arpv_pkg::LEVEL_W+1)'(mag);
		if (!play_s1) begin
			sum_next = level_q;
		end else if (sum_wide[arpv_pkg::LEVEL_W]) begin
			sum_next = '1;
		end else begin
			sum_next = sum_wide[arpv_pkg::LEVEL_W-1:0];
		end
		level_hi = sum_next[arpv_pkg::LEVEL_W-1:arpv_pkg::VU_SHIFT];
		if (level_hi > (arpv_pkg::LEVEL_W-arpv_pkg::VU_SHIFT)'(arpv_pkg::VU_MAX)) begin
			vu_new = arpv_pkg::VU_MAX;
		end else begin
			vu_new = arpv_pkg::VU_W'(level_hi);
		end
		prod = $signed(rd_data) * $signed({1'b0, gain_q});
		pot  = {k_s1, 3'b000};
		vol_x_pot = (arpv_pkg::GAIN_W+1)'(usb_volume_q) * (arpv_pkg::GAIN_W+1)'(pot);
		if (usb_volume_q == arpv_pkg::VOL_MIN_CODE) begin
			gain_new = '0;
		end else begin
			gain_new = vol_x_pot[arpv_pkg::GAIN_W-1:0];
		end
		// percentage and VU level as they stand after this tick
		if (window_s1) begin
			pct_next = arpv_pkg::pct_of(k_s1);
			vu_next  = vu_new;
		end else begin
			pct_next = pct_q;
			vu_next  = vu_q;
		end
	end

	// meter and gain state, updated as a tick leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= '0;
			level_q <= '0;
			pct_q   <= '0;
			vu_q    <= '0;
		end else if (adv && valid_s1) begin
			pct_q <= pct_next;
			vu_q  <= vu_next;
			if (window_s1) begin
				level_q <= '0;
				gain_q  <= gain_new;
			end else begin
				level_q <= sum_next;
			end
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			quiet_s2  <= !play_s1 || mute_s1;
			window_s2 <= window_s1;
			hi_s2     <= prod[31:16];
			pct_s2    <= pct_next;
			vu_s2     <= vu_next;
		end
	end

	// bias and DAC code
	assign biased = hi_s2 + arpv_pkg::BIAS;

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			done_q    <= window_s2;
			pct_out_q <= pct_s2;
			vu_out_q  <= vu_s2;
			if (quiet_s2) begin
				dac_q <= arpv_pkg::DAC_MID;
			end else begin
				dac_q <= biased[arpv_pkg::SAMPLE_W-1:arpv_pkg::SAMPLE_W-arpv_pkg::DAC_W];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign dac_code    = dac_q;
	assign vol_pct     = pct_out_q;
	assign vu_level    = vu_out_q;
	assign window_done = done_q;

	`ASSERT_CLK(a_window_clears_sum, clk, arst_n,
		(adv && valid_s1 && window_s1) |=> (level_q == '0),
		"VU sum not cleared after a window tick")
	`ASSERT_CLK(a_idle_sum_holds, clk, arst_n,
		(adv && valid_s1 && !play_s1 && !window_s1) |=> $stable(level_q),
		"VU sum changed on a stopped tick")
	`ASSERT_CLK(a_quiet_mid, clk, arst_n,
		(adv && valid_s2 && quiet_s2) |=> (dac_code == arpv_pkg::DAC_MID),
		"muted or stopped tick did not give mid-scale")

endmodule

`default_nettype wire
